// ===== hdl/lcf_pkg.sv =====
// shared types, constants and codes for the linear calibration fit block
package lcf_pkg;

    localparam int MAX_POINTS = 32;
    localparam int PT_AW      = $clog2(MAX_POINTS);
    localparam int CNT_W      = PT_AW + 1;
    localparam int FRAC_BITS  = 16;
    localparam int MARGIN_W   = 21;
    localparam int SUM_W      = 38;
    localparam int SQ_W       = 70;
    localparam int WIDE_W     = 176;

    localparam logic [MARGIN_W-1:0] MARGIN_RST = 21'd6554;

    localparam logic [31:0] R2_ONE   = 32'd1 << FRAC_BITS;
    localparam logic [31:0] S32_MAX  = 32'h7FFF_FFFF;
    localparam logic [31:0] S32_MIN  = 32'h8000_0000;
    localparam logic [31:0] CONV_NF  = 32'hFFFF_FFFF << FRAC_BITS;

    localparam logic [1:0] OP_ADD  = 2'd0;
    localparam logic [1:0] OP_FIT  = 2'd1;
    localparam logic [1:0] OP_CONV = 2'd2;

    localparam logic [2:0] STS_OK         = 3'd0;
    localparam logic [2:0] STS_NOT_FITTED = 3'd1;
    localparam logic [2:0] STS_TOO_FEW    = 3'd2;
    localparam logic [2:0] STS_DEGENERATE = 3'd3;
    localparam logic [2:0] STS_FULL       = 3'd4;

    typedef logic signed [WIDE_W-1:0] t_wide;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] concentration_in;
        logic signed [31:0] od_in;
    } t_in;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] slope_out;
        logic signed [31:0] intercept_out;
        logic [16:0]        r_squared_out;
        logic signed [31:0] concentration_out;
        logic               in_range;
    } t_out;

    typedef struct packed {
        t_wide a;
        t_wide b;
    } t_mul_req;

    typedef struct packed {
        t_wide num;
        t_wide den;
        logic  r2_mode;
    } t_div_req;

    typedef enum logic [3:0] {
        STEP_NSXX, STEP_SXSX, STEP_NSXY, STEP_SXSY, STEP_SYSXX, STEP_SXSXY,
        STEP_NSYY, STEP_SYSY, STEP_DSLOPE, STEP_DICPT, STEP_NUM2, STEP_DENVY,
        STEP_DR2, STEP_DCONV
    } t_step;

endpackage

// ===== hdl/lcf_mul.sv =====
// serial shift-add signed multiplier, one multiplier bit per cycle
module lcf_mul (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  lcf_pkg::t_mul_req i_req,
    output logic             o_done,
    output lcf_pkg::t_wide   o_prod
);
    localparam int W = lcf_pkg::WIDE_W;

    logic           r_busy, r_done, r_neg;
    logic [W-1:0]   r_ua, r_ub, r_acc;
    lcf_pkg::t_wide r_prod;
    logic [W-1:0]   ua, ub;

    always_comb begin
        ua = i_req.a[W-1] ? unsigned'(-i_req.a) : unsigned'(i_req.a);
        ub = i_req.b[W-1] ? unsigned'(-i_req.b) : unsigned'(i_req.b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_neg  <= i_req.a[W-1] ^ i_req.b[W-1];
                r_ua   <= ua;
                r_ub   <= ub;
                r_acc  <= '0;
            end else if (r_busy) begin
                if (r_ub == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_prod <= r_neg ? -signed'(r_acc) : signed'(r_acc);
                end else begin
                    if (r_ub[0]) begin
                        r_acc <= r_acc + r_ua;
                    end
                    r_ua <= r_ua << 1;
                    r_ub <= r_ub >> 1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_prod;

endmodule

// ===== hdl/lcf_div.sv =====
// restoring divider, rounds to nearest (ties away from zero) and saturates
module lcf_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  lcf_pkg::t_div_req  i_req,
    output logic               o_done,
    output logic signed [31:0] o_quot
);
    localparam int W  = lcf_pkg::WIDE_W;
    localparam int CW = $clog2(W);

    logic               r_busy, r_fin, r_done, r_neg, r_r2;
    logic [W-1:0]       r_dvd, r_q;
    logic [W:0]         r_rem, r_d2;
    logic [CW-1:0]      r_cnt;
    logic signed [31:0] r_quot;

    logic         num_neg, den_neg, ge, q_hi;
    logic [W-1:0] na, nd;
    logic [W:0]   rem_sh;
    logic [31:0]  mag, fin_val, zero_val;

    always_comb begin
        num_neg = i_req.num[W-1];
        den_neg = i_req.den[W-1];
        na      = num_neg ? unsigned'(-i_req.num) : unsigned'(i_req.num);
        nd      = den_neg ? unsigned'(-i_req.den) : unsigned'(i_req.den);
        rem_sh  = {r_rem[W-1:0], r_dvd[W-1]};
        ge      = rem_sh >= r_d2;
        q_hi    = |r_q[W-1:32];
        mag     = r_q[31:0];
        // division by zero: zero over zero is zero, else saturate by sign
        if (na == '0) begin
            zero_val = '0;
        end else if (num_neg) begin
            zero_val = i_req.r2_mode ? 32'd0 : lcf_pkg::S32_MIN;
        end else begin
            zero_val = i_req.r2_mode ? lcf_pkg::R2_ONE : lcf_pkg::S32_MAX;
        end
        if (r_r2) begin
            if (r_neg) begin
                fin_val = '0;
            end else begin
                fin_val = (q_hi || mag > lcf_pkg::R2_ONE) ? lcf_pkg::R2_ONE : mag;
            end
        end else if (r_neg) begin
            fin_val = (q_hi || mag > lcf_pkg::S32_MIN) ? lcf_pkg::S32_MIN : -mag;
        end else begin
            fin_val = (q_hi || mag[31]) ? lcf_pkg::S32_MAX : mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_neg <= num_neg ^ den_neg;
                r_r2  <= i_req.r2_mode;
                if (nd == '0) begin
                    r_quot <= signed'(zero_val);
                    r_done <= 1'b1;
                end else begin
                    // (2|n| + |d|) / (2|d|) gives the rounded magnitude
                    r_dvd  <= (na << 1) + nd;
                    r_d2   <= {nd, 1'b0};
                    r_rem  <= '0;
                    r_q    <= '0;
                    r_cnt  <= CW'(W - 1);
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_rem <= ge ? rem_sh - r_d2 : rem_sh;
                r_q   <= {r_q[W-2:0], ge};
                r_dvd <= r_dvd << 1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end else if (r_fin) begin
                r_fin  <= 1'b0;
                r_quot <= signed'(fin_val);
                r_done <= 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== hdl/linear_calibration_fit.sv =====
// top level: calibration point store, least-squares fit and od conversion
//
//  channel  direction  handshake                  payload
//  in       in         i_in_valid / o_in_stall    i_in_data  (lcf_pkg::t_in)
//  out      out        o_out_valid / i_out_stall  o_out_data (lcf_pkg::t_out)
//  cfg      in         i_cfg_valid / o_cfg_ready  i_cfg_data (range margin)
//
//  add point and unused opcode: through S_OUT to the output register
//  convert: one pass of the serial divider (176 steps)
//  fit: S_RD, S_P0 to S_P3 per point (one 32x32 multiplier over the point memory),
//  then 2, 8 or 10 serial multiplies (one multiplier bit per cycle) and up to 3 divides
//  one request at a time; a finished result may wait in the output register
//  reset is synchronous; the point memory needs no clearing pass
module linear_calibration_fit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  lcf_pkg::t_in                   i_in_data,
    output logic                           o_in_stall,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output lcf_pkg::t_out                  o_out_data,
    input  logic                           i_cfg_valid,
    input  logic [lcf_pkg::MARGIN_W-1:0]   i_cfg_data,
    output logic                           o_cfg_ready
);
    localparam int W = lcf_pkg::WIDE_W;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_RD     = 11'b00000000010,
        S_P0     = 11'b00000000100,
        S_P1     = 11'b00000001000,
        S_P2     = 11'b00000010000,
        S_P3     = 11'b00000100000,
        S_MSTART = 11'b00001000000,
        S_MWAIT  = 11'b00010000000,
        S_DSTART = 11'b00100000000,
        S_DWAIT  = 11'b01000000000,
        S_OUT    = 11'b10000000000
    } t_state;

    t_state r_state;
    lcf_pkg::t_step r_step;

    logic [63:0] r_mem [lcf_pkg::MAX_POINTS];
    logic [63:0] r_rd;

    logic [lcf_pkg::CNT_W-1:0] r_count, r_idx;
    logic signed [lcf_pkg::SUM_W-1:0] r_sx, r_sy;
    logic signed [lcf_pkg::SQ_W-1:0]  r_sxx, r_syy, r_sxy;
    logic signed [63:0] r_prod;
    lcf_pkg::t_wide r_t1, r_t2, r_den, r_num, r_icn, r_vy;

    logic signed [31:0] r_slope, r_intercept, r_min_od, r_max_od, r_od, r_conc;
    logic [16:0] r_r2;
    logic        r_fitted, r_flag;
    logic [2:0]  r_status;
    logic [lcf_pkg::MARGIN_W-1:0] r_margin;

    logic          r_out_valid;
    lcf_pkg::t_out r_out;

    logic in_acc, add_ok, rd_en;
    logic signed [31:0] x_s, y_s;
    logic signed [33:0] od34, lo34, hi34;
    logic signed [32:0] od_diff;
    lcf_pkg::t_wide diff;

    lcf_pkg::t_mul_req mul_req;
    lcf_pkg::t_wide    mul_prod;
    logic              mul_done;
    lcf_pkg::t_div_req div_req;
    logic signed [31:0] div_quot;
    logic              div_done;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        in_acc  = i_in_valid && (r_state == S_IDLE);
        add_ok  = r_count < lcf_pkg::CNT_W'(lcf_pkg::MAX_POINTS);
        rd_en   = (r_state == S_RD);
        x_s     = signed'(r_rd[63:32]);
        y_s     = signed'(r_rd[31:0]);
        diff    = r_t1 - mul_prod;
        od34    = 34'(i_in_data.od_in);
        lo34    = 34'(r_min_od) - signed'(34'(r_margin));
        hi34    = 34'(r_max_od) + signed'(34'(r_margin));
        od_diff = 33'(r_od) - 33'(r_intercept);
    end

    // operand selection for the shared serial units
    always_comb begin
        mul_req = '0;
        case (r_step)
            lcf_pkg::STEP_NSXX:  mul_req = '{a: W'(r_sxx), b: W'(r_count)};
            lcf_pkg::STEP_SXSX:  mul_req = '{a: W'(r_sx),  b: W'(r_sx)};
            lcf_pkg::STEP_NSXY:  mul_req = '{a: W'(r_sxy), b: W'(r_count)};
            lcf_pkg::STEP_SXSY:  mul_req = '{a: W'(r_sx),  b: W'(r_sy)};
            lcf_pkg::STEP_SYSXX: mul_req = '{a: W'(r_sxx), b: W'(r_sy)};
            lcf_pkg::STEP_SXSXY: mul_req = '{a: W'(r_sxy), b: W'(r_sx)};
            lcf_pkg::STEP_NSYY:  mul_req = '{a: W'(r_syy), b: W'(r_count)};
            lcf_pkg::STEP_SYSY:  mul_req = '{a: W'(r_sy),  b: W'(r_sy)};
            lcf_pkg::STEP_NUM2:  mul_req = '{a: r_num,     b: r_num};
            lcf_pkg::STEP_DENVY: mul_req = '{a: r_vy,      b: r_den};
            default:             mul_req = '0;
        endcase
        div_req = '0;
        case (r_step)
            lcf_pkg::STEP_DSLOPE: div_req = '{num: r_num <<< lcf_pkg::FRAC_BITS,
                                              den: r_den, r2_mode: 1'b0};
            lcf_pkg::STEP_DICPT:  div_req = '{num: r_icn, den: r_den, r2_mode: 1'b0};
            lcf_pkg::STEP_DR2:    div_req = '{num: r_t1 <<< lcf_pkg::FRAC_BITS,
                                              den: r_t2, r2_mode: 1'b1};
            lcf_pkg::STEP_DCONV:  div_req = '{num: W'(od_diff) <<< lcf_pkg::FRAC_BITS,
                                              den: W'(r_slope), r2_mode: 1'b0};
            default:              div_req = '0;
        endcase
    end

    lcf_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_MSTART),
        .i_req   (mul_req),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    lcf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_DSTART),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // point memory: {concentration, od}, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (in_acc && i_in_data.opcode == lcf_pkg::OP_ADD && add_ok) begin
            r_mem[r_count[lcf_pkg::PT_AW-1:0]] <=
                {i_in_data.concentration_in, i_in_data.od_in};
        end
        if (rd_en) begin
            r_rd <= r_mem[r_idx[lcf_pkg::PT_AW-1:0]];
        end
    end

    // datapath work registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_sx  <= '0;
            r_sy  <= '0;
            r_sxx <= '0;
            r_syy <= '0;
            r_sxy <= '0;
            r_od  <= i_in_data.od_in;
        end
        case (r_state)
            S_P0: begin
                r_sx   <= r_sx + lcf_pkg::SUM_W'(x_s);
                r_sy   <= r_sy + lcf_pkg::SUM_W'(y_s);
                r_prod <= 64'(x_s) * 64'(x_s);
            end
            S_P1: begin
                r_sxx  <= r_sxx + lcf_pkg::SQ_W'(r_prod);
                r_prod <= 64'(y_s) * 64'(y_s);
            end
            S_P2: begin
                r_syy  <= r_syy + lcf_pkg::SQ_W'(r_prod);
                r_prod <= 64'(x_s) * 64'(y_s);
            end
            S_P3: begin
                r_sxy  <= r_sxy + lcf_pkg::SQ_W'(r_prod);
            end
            S_MWAIT: begin
                if (mul_done) begin
                    case (r_step)
                        lcf_pkg::STEP_SXSX:  r_den <= diff;
                        lcf_pkg::STEP_SXSY:  r_num <= diff;
                        lcf_pkg::STEP_SXSXY: r_icn <= diff;
                        lcf_pkg::STEP_SYSY:  r_vy  <= diff;
                        lcf_pkg::STEP_DENVY: r_t2  <= mul_prod;
                        default:             r_t1  <= mul_prod;
                    endcase
                end
            end
            default: ;
        endcase
    end

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= lcf_pkg::STEP_NSXX;
            r_count     <= '0;
            r_idx       <= '0;
            r_slope     <= '0;
            r_intercept <= '0;
            r_r2        <= '0;
            r_min_od    <= '0;
            r_max_od    <= '0;
            r_fitted    <= 1'b0;
            r_margin    <= lcf_pkg::MARGIN_RST;
            r_out_valid <= 1'b0;
            r_status    <= lcf_pkg::STS_OK;
            r_conc      <= '0;
            r_flag      <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_margin <= i_cfg_data;
            end
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_status <= lcf_pkg::STS_OK;
                        r_conc   <= '0;
                        r_flag   <= 1'b0;
                        r_state  <= S_OUT;
                        case (i_in_data.opcode)
                            lcf_pkg::OP_ADD: begin
                                if (add_ok) begin
                                    r_count <= r_count + 1'b1;
                                end else begin
                                    r_status <= lcf_pkg::STS_FULL;
                                end
                            end
                            lcf_pkg::OP_FIT: begin
                                if (r_count < lcf_pkg::CNT_W'(2)) begin
                                    r_status <= lcf_pkg::STS_TOO_FEW;
                                end else begin
                                    r_idx   <= '0;
                                    r_state <= S_RD;
                                end
                            end
                            lcf_pkg::OP_CONV: begin
                                if (!r_fitted) begin
                                    r_status <= lcf_pkg::STS_NOT_FITTED;
                                    r_conc   <= signed'(lcf_pkg::CONV_NF);
                                end else begin
                                    r_flag  <= (od34 >= lo34) && (od34 <= hi34);
                                    r_step  <= lcf_pkg::STEP_DCONV;
                                    r_state <= S_DSTART;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_RD: r_state <= S_P0;
                S_P0: begin
                    if (r_idx == '0 || y_s < r_min_od) begin
                        r_min_od <= y_s;
                    end
                    if (r_idx == '0 || y_s > r_max_od) begin
                        r_max_od <= y_s;
                    end
                    r_state <= S_P1;
                end
                S_P1: r_state <= S_P2;
                S_P2: r_state <= S_P3;
                S_P3: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx + 1'b1 == r_count) begin
                        r_step  <= lcf_pkg::STEP_NSXX;
                        r_state <= S_MSTART;
                    end else begin
                        r_state <= S_RD;
                    end
                end
                S_MSTART: r_state <= S_MWAIT;
                S_MWAIT: begin
                    if (mul_done) begin
                        r_state <= S_MSTART;
                        case (r_step)
                            lcf_pkg::STEP_NSXX:  r_step <= lcf_pkg::STEP_SXSX;
                            lcf_pkg::STEP_SXSX: begin
                                // a zero denominator means a degenerate fit
                                if (diff == '0) begin
                                    r_status <= lcf_pkg::STS_DEGENERATE;
                                    r_state  <= S_OUT;
                                end else begin
                                    r_step <= lcf_pkg::STEP_NSXY;
                                end
                            end
                            lcf_pkg::STEP_NSXY:  r_step <= lcf_pkg::STEP_SXSY;
                            lcf_pkg::STEP_SXSY:  r_step <= lcf_pkg::STEP_SYSXX;
                            lcf_pkg::STEP_SYSXX: r_step <= lcf_pkg::STEP_SXSXY;
                            lcf_pkg::STEP_SXSXY: r_step <= lcf_pkg::STEP_NSYY;
                            lcf_pkg::STEP_NSYY:  r_step <= lcf_pkg::STEP_SYSY;
                            lcf_pkg::STEP_SYSY: begin
                                r_step  <= lcf_pkg::STEP_DSLOPE;
                                r_state <= S_DSTART;
                            end
                            lcf_pkg::STEP_NUM2:  r_step <= lcf_pkg::STEP_DENVY;
                            default: begin
                                r_step  <= lcf_pkg::STEP_DR2;
                                r_state <= S_DSTART;
                            end
                        endcase
                    end
                end
                S_DSTART: r_state <= S_DWAIT;
                S_DWAIT: begin
                    if (div_done) begin
                        r_state <= S_OUT;
                        case (r_step)
                            lcf_pkg::STEP_DSLOPE: begin
                                r_slope <= div_quot;
                                r_step  <= lcf_pkg::STEP_DICPT;
                                r_state <= S_DSTART;
                            end
                            lcf_pkg::STEP_DICPT: begin
                                r_intercept <= div_quot;
                                // flat od: r squared is one
                                if (r_vy[W-1] || r_vy == '0) begin
                                    r_r2     <= lcf_pkg::R2_ONE[16:0];
                                    r_fitted <= 1'b1;
                                end else begin
                                    r_step  <= lcf_pkg::STEP_NUM2;
                                    r_state <= S_MSTART;
                                end
                            end
                            lcf_pkg::STEP_DR2: begin
                                r_r2     <= div_quot[16:0];
                                r_fitted <= 1'b1;
                            end
                            default: r_conc <= div_quot;
                        endcase
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_out <= '{status: r_status, slope_out: r_slope,
                                   intercept_out: r_intercept, r_squared_out: r_r2,
                                   concentration_out: r_conc, in_range: r_flag};
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== hdl/lcf_checker.sv =====
// port-level checks for the linear calibration fit block, bound to the top level
module lcf_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input lcf_pkg::t_out o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    a_not_fitted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == lcf_pkg::STS_NOT_FITTED |->
            o_out_data.concentration_out == signed'(lcf_pkg::CONV_NF) &&
            !o_out_data.in_range)
        else $error("unfitted conversion gave wrong value");

    a_range_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.in_range |-> o_out_data.status == lcf_pkg::STS_OK)
        else $error("range flag set on failing request");

    a_r2_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.r_squared_out <= lcf_pkg::R2_ONE[16:0])
        else $error("r squared above one");

endmodule

bind linear_calibration_fit lcf_checker u_lcf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

// ===== bench/linear_calibration_fit_tb.sv =====
// self-checking testbench for the linear calibration fit block
module linear_calibration_fit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_NOP = 2'd3;
    localparam int RAND_ITEMS = 1300;
    localparam int CYCLE_LIMIT = 20_000_000;
    localparam int HOLD_CYCLES = 3000;

    typedef logic signed [255:0] t_acc;

    typedef struct {
        logic [1:0]    op;
        logic [31:0]   conc;
        logic [31:0]   od;
        bit            known;
        lcf_pkg::t_out want;
    } t_row;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    lcf_pkg::t_in                 in_data = '0;
    logic                         in_stall;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    lcf_pkg::t_out                out_data;
    logic                         cfg_valid = 1'b0;
    logic [lcf_pkg::MARGIN_W-1:0] cfg_data = '0;
    logic                         cfg_ready;

    // predictor state
    longint pt_conc [lcf_pkg::MAX_POINTS];
    longint pt_od [lcf_pkg::MAX_POINTS];
    int     n_points = 0;
    longint cur_slope = 0, cur_icpt = 0, cur_r2 = 0, od_lo = 0, od_hi = 0;
    bit     have_fit = 1'b0;
    longint margin = longint'(lcf_pkg::MARGIN_RST);

    lcf_pkg::t_out result_q[$];
    int     mismatches = 0;
    int     cycles = 0;
    int     burst_left = 0;
    int     hold_asks = 0;
    int     hold_seen = 0;
    int     hold_left = 0;
    int     stall_mode = 0;
    int     mode_left = 0;

    linear_calibration_fit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .i_cfg_data  (cfg_data),
        .o_cfg_ready (cfg_ready)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("linear_calibration_fit verification failed");
            $finish;
        end
    end

    // round to nearest, ties away from zero, saturated to [lo, hi]
    function automatic longint round_div(t_acc num, t_acc den, longint lo, longint hi);
        t_acc na, nd, q;
        logic neg;
        neg = num[255] ^ den[255];
        na = num[255] ? -num : num;
        nd = den[255] ? -den : den;
        if (nd == 0)
            return (na == 0) ? 0 : (num[255] ? lo : hi);
        q = ((na <<< 1) + nd) / (nd <<< 1);
        if (neg)
            return (q > t_acc'(-lo)) ? lo : -longint'(q);
        return (q > t_acc'(hi)) ? hi : longint'(q);
    endfunction

    function automatic logic [2:0] fit_line();
        longint sx, sy, x, y;
        t_acc sxx, syy, sxy, den, num, icn, vy;
        sx = 0; sy = 0; sxx = 0; syy = 0; sxy = 0;
        if (n_points < 2) return lcf_pkg::STS_TOO_FEW;
        od_lo = pt_od[0];
        od_hi = pt_od[0];
        for (int i = 0; i < n_points; i++) begin
            x = pt_conc[i];
            y = pt_od[i];
            sx += x;
            sy += y;
            sxx += t_acc'(x * x);
            syy += t_acc'(y * y);
            sxy += t_acc'(x * y);
            if (y < od_lo) od_lo = y;
            if (y > od_hi) od_hi = y;
        end
        den = t_acc'(n_points) * sxx - t_acc'(sx) * t_acc'(sx);
        if ((den[255] ? -den : den) * t_acc'(64'd10000000000)
            < (t_acc'(1) <<< (2 * lcf_pkg::FRAC_BITS)))
            return lcf_pkg::STS_DEGENERATE;
        num = t_acc'(n_points) * sxy - t_acc'(sx) * t_acc'(sy);
        icn = t_acc'(sy) * sxx - t_acc'(sx) * sxy;
        vy = t_acc'(n_points) * syy - t_acc'(sy) * t_acc'(sy);
        cur_slope = round_div(num <<< lcf_pkg::FRAC_BITS, den,
                              -64'sd2147483648, 64'sd2147483647);
        cur_icpt = round_div(icn, den, -64'sd2147483648, 64'sd2147483647);
        if (vy <= 0)
            cur_r2 = longint'(1) << lcf_pkg::FRAC_BITS;
        else
            cur_r2 = round_div((num * num) <<< lcf_pkg::FRAC_BITS, den * vy, 0,
                               longint'(1) << lcf_pkg::FRAC_BITS);
        have_fit = 1'b1;
        return lcf_pkg::STS_OK;
    endfunction

    function automatic lcf_pkg::t_out calib_predict(lcf_pkg::t_in req);
        lcf_pkg::t_out r;
        longint od, conc;
        r = '0;
        od = longint'(req.od_in);
        conc = 0;
        case (req.opcode)
            lcf_pkg::OP_ADD: begin
                if (n_points < lcf_pkg::MAX_POINTS) begin
                    pt_conc[n_points] = longint'(req.concentration_in);
                    pt_od[n_points] = od;
                    n_points++;
                end else begin
                    r.status = lcf_pkg::STS_FULL;
                end
            end
            lcf_pkg::OP_FIT: r.status = fit_line();
            lcf_pkg::OP_CONV: begin
                if (!have_fit) begin
                    r.status = lcf_pkg::STS_NOT_FITTED;
                    conc = -(longint'(1) << lcf_pkg::FRAC_BITS);
                end else begin
                    conc = round_div(t_acc'(od - cur_icpt) <<< lcf_pkg::FRAC_BITS,
                                     t_acc'(cur_slope),
                                     -64'sd2147483648, 64'sd2147483647);
                    r.in_range = (od >= od_lo - margin) && (od <= od_hi + margin);
                end
            end
            default: ;
        endcase
        r.slope_out = cur_slope[31:0];
        r.intercept_out = cur_icpt[31:0];
        r.r_squared_out = cur_r2[16:0];
        r.concentration_out = conc[31:0];
        return r;
    endfunction

    // receiver: own stall pattern, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            out_stall = 1'b1;
            hold_left--;
        end else if (hold_seen != hold_asks) begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
            out_stall = 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 400);
            end
            mode_left--;
            case (stall_mode)
                0: out_stall = 1'b0;
                1: out_stall = ($urandom_range(0, 99) < 30);
                2: out_stall = ($urandom_range(0, 99) < 75);
                default: out_stall = ~out_stall;
            endcase
        end
    end

    always @(posedge i_clk) begin
        lcf_pkg::t_out want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (result_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", out_data);
            end else begin
                want = result_q.pop_front();
                if (out_data.status !== want.status
                    || out_data.slope_out !== want.slope_out
                    || out_data.intercept_out !== want.intercept_out
                    || out_data.r_squared_out !== want.r_squared_out
                    || out_data.concentration_out !== want.concentration_out
                    || out_data.in_range !== want.in_range) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %p, got %p", want, out_data);
                end
            end
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic offer(input lcf_pkg::t_in req, input bit known,
                         input lcf_pkg::t_out typed);
        lcf_pkg::t_out p;
        if (burst_left == 0) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 25)) @(negedge i_clk);
            burst_left = $urandom_range(1, 60);
        end
        burst_left--;
        in_valid = 1'b1;
        in_data = req;
        do @(posedge i_clk); while (in_stall);
        p = calib_predict(req);
        result_q.push_back(known ? typed : p);
        @(negedge i_clk);
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_margin(input logic [lcf_pkg::MARGIN_W-1:0] v);
        cfg_valid = 1'b1;
        cfg_data = v;
        do @(posedge i_clk); while (!cfg_ready);
        margin = longint'(v);
        @(negedge i_clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: begin
                case ($urandom_range(0, 4))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    3: return 32'hFFFF_FFFF;
                    default: return 32'h0001_0000;
                endcase
            end
            default: return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
        endcase
    endfunction

    task automatic random_phase(input int count);
        lcf_pkg::t_in req;
        int pick;
        longint base;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            req.concentration_in = rand_word();
            req.od_in = rand_word();
            if (n_points < lcf_pkg::MAX_POINTS)
                req.opcode = (pick < 60) ? lcf_pkg::OP_ADD : (pick < 75) ? lcf_pkg::OP_FIT
                           : (pick < 95) ? lcf_pkg::OP_CONV : OP_NOP;
            else
                req.opcode = (pick < 10) ? lcf_pkg::OP_ADD : (pick < 18) ? lcf_pkg::OP_FIT
                           : (pick < 96) ? lcf_pkg::OP_CONV : OP_NOP;
            // convert near the range edges
            if (req.opcode == lcf_pkg::OP_CONV && $urandom_range(0, 1)) begin
                base = $urandom_range(0, 1) ? od_lo : od_hi;
                base += longint'($urandom_range(0, 32'(2 * (margin + 4)))) - (margin + 4);
                req.od_in = base[31:0];
            end
            offer(req, 1'b0, '0);
        end
    endtask

    t_row rows[];

    initial begin
        lcf_pkg::t_in req;
        lcf_pkg::t_out ok0, nf0, tf0;
        ok0 = '0;
        nf0 = '0;
        nf0.status = lcf_pkg::STS_NOT_FITTED;
        nf0.concentration_out = lcf_pkg::CONV_NF;
        tf0 = '0;
        tf0.status = lcf_pkg::STS_TOO_FEW;
        rows = new[25];
        rows[0]  = '{lcf_pkg::OP_CONV, 32'd0, 32'd0, 1'b1, nf0};
        rows[1]  = '{lcf_pkg::OP_FIT, 32'd0, 32'd0, 1'b1, tf0};
        rows[2]  = '{OP_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, ok0};
        rows[3]  = '{lcf_pkg::OP_ADD, 32'd0, 32'd5, 1'b1, ok0};
        rows[4]  = '{lcf_pkg::OP_FIT, 32'd0, 32'd0, 1'b1, tf0};
        rows[5]  = '{lcf_pkg::OP_ADD, 32'd0, 32'd5, 1'b1, ok0};
        rows[6]  = '{lcf_pkg::OP_FIT, 32'd0, 32'd0, 1'b1,
                     '{lcf_pkg::STS_DEGENERATE, 0, 0, 0, 0, 0}};
        rows[7]  = '{lcf_pkg::OP_CONV, 32'd0, 32'd5, 1'b1, nf0};
        rows[8]  = '{lcf_pkg::OP_ADD, 32'h0001_0000, 32'd5, 1'b1, ok0};
        // flat od: zero slope, intercept 5, r squared one
        rows[9]  = '{lcf_pkg::OP_FIT, 32'd0, 32'd0, 1'b1,
                     '{lcf_pkg::STS_OK, 0, 5, lcf_pkg::R2_ONE[16:0], 0, 0}};
        rows[10] = '{lcf_pkg::OP_CONV, 32'd0, 32'd5, 1'b1,
                     '{lcf_pkg::STS_OK, 0, 5, lcf_pkg::R2_ONE[16:0], 0, 1}};
        rows[11] = '{lcf_pkg::OP_CONV, 32'd0, 32'd6, 1'b0, ok0};
        rows[12] = '{lcf_pkg::OP_CONV, 32'd0, 32'd4, 1'b0, ok0};
        rows[13] = '{lcf_pkg::OP_CONV, 32'd0, 32'h7FFF_FFFF, 1'b0, ok0};
        rows[14] = '{lcf_pkg::OP_CONV, 32'd0, 32'h8000_0000, 1'b0, ok0};
        rows[15] = '{lcf_pkg::OP_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, ok0};
        rows[16] = '{lcf_pkg::OP_ADD, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, ok0};
        rows[17] = '{lcf_pkg::OP_ADD, 32'h0001_0000, 32'h0002_0000, 1'b0, ok0};
        rows[18] = '{lcf_pkg::OP_FIT, 32'd0, 32'd0, 1'b0, ok0};
        rows[19] = '{lcf_pkg::OP_CONV, 32'd0, 32'd0, 1'b0, ok0};
        rows[20] = '{lcf_pkg::OP_CONV, 32'd0, 32'h7FFF_FFFF, 1'b0, ok0};
        rows[21] = '{lcf_pkg::OP_CONV, 32'd0, 32'h8000_0000, 1'b0, ok0};
        rows[22] = '{lcf_pkg::OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, ok0};
        rows[23] = '{lcf_pkg::OP_FIT, 32'd0, 32'd0, 1'b0, ok0};
        rows[24] = '{lcf_pkg::OP_CONV, 32'd0, 32'h0001_0000, 1'b0, ok0};

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (rows[i]) begin
            req.opcode = rows[i].op;
            req.concentration_in = rows[i].conc;
            req.od_in = rows[i].od;
            offer(req, rows[i].known, rows[i].want);
        end
        drain();
        write_margin('0);
        random_phase(RAND_ITEMS / 3);
        drain();
        write_margin(21'd1048576);
        hold_asks++;
        random_phase(RAND_ITEMS / 3);
        drain();
        write_margin(lcf_pkg::MARGIN_W'($urandom_range(0, 1048576)));
        random_phase(RAND_ITEMS / 3);
        drain();
        repeat (300) @(posedge i_clk);

        if (mismatches == 0 && result_q.size() == 0)
            $display("linear_calibration_fit verification clean");
        else
            $display("linear_calibration_fit verification failed");
        $finish;
    end
endmodule
